>>> rtl/bsc_pkg.sv
// Shared types and constants for the barometric compensation block.
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int unsigned SampleWidth = 20;
	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CfgAddrWidth = 5;
	localparam int unsigned CfgDataWidth = 64;

	localparam logic [CfgAddrWidth-1:0] AddrTempCal = 5'd0;
	localparam logic [CfgAddrWidth-1:0] AddrPressLow = 5'd8;
	localparam logic [CfgAddrWidth-1:0] AddrPressHigh = 5'd16;
	localparam logic [CfgAddrWidth-1:0] AddrPressLast = 5'd24;

	localparam logic [31:0] PressOffset = 32'd64000;
	localparam logic [31:0] AdcFull = 32'd1048576;
	localparam logic [31:0] PressScale = 32'd3125;
	localparam logic [31:0] SignBit = 32'h8000_0000;
	localparam logic [31:0] OneQ15 = 32'd32768;
	localparam logic [31:0] RoundHalf = 32'd128;

	// datapath micro-operations, one per sequencer step
	typedef enum logic [4:0] {
		OP_T_A   = 5'd0,
		OP_T_V1  = 5'd1,
		OP_T_B   = 5'd2,
		OP_T_BB  = 5'd3,
		OP_T_V2  = 5'd4,
		OP_T_FIN = 5'd5,
		OP_T_RES = 5'd6,
		OP_P_V1  = 5'd7,
		OP_P_SQ  = 5'd8,
		OP_P_X6  = 5'd9,
		OP_P_X5  = 5'd10,
		OP_P_V2  = 5'd11,
		OP_P_Y3  = 5'd12,
		OP_P_Y2  = 5'd13,
		OP_P_Y1  = 5'd14,
		OP_P_DEN = 5'd15,
		OP_P_NUM = 5'd16,
		OP_P_DIV = 5'd17,
		OP_P_W   = 5'd18,
		OP_P_Z9  = 5'd19,
		OP_P_Z8  = 5'd20,
		OP_P_RES = 5'd21,
		OP_NONE  = 5'd22
	} op_t;

	typedef struct packed {
		logic  load;      // capture input transaction
		logic  step;      // execute op
		op_t   op;
		logic  div_start;
		logic  take;      // result handed to output register
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic div_busy;
		logic den_zero;
	} dp_stat_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		asr32 = 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] w);
		sx16 = {{16{w[15]}}, w};
	endfunction

endpackage

>>> rtl/bsc_if.sv
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps
interface bsc_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [bsc_pkg::SampleWidth-1:0] raw_sample;
	modport source (output valid, kind, raw_sample, input ready);
	modport sink (input valid, kind, raw_sample, output ready);
endinterface

interface bsc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         result_kind;
	logic [bsc_pkg::ValueWidth-1:0] result_value;
	logic                         divisor_zero;
	modport source (output valid, result_kind, result_value, divisor_zero, input ready);
	modport sink (input valid, result_kind, result_value, divisor_zero, output ready);
endinterface

>>> rtl/bsc_datapath.sv
// Compensation datapath: shared multiplier, accumulators and a radix-2 divider.
`timescale 1ns / 1ps
module bsc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bsc_pkg::dp_cmd_t             cmd,
	output bsc_pkg::dp_stat_t            stat,
	input  logic                         in_kind,
	input  logic [bsc_pkg::SampleWidth-1:0] in_raw,
	input  logic [47:0]                  temp_cal,
	input  logic [63:0]                  press_cal_low,
	input  logic [63:0]                  press_cal_high,
	input  logic [15:0]                  press_cal_last,
	output logic [31:0]                  res_value,
	output logic                         res_flag
);
	import bsc_pkg::*;

	logic        kind_q;
	logic [19:0] adc_q;
	logic [31:0] fine_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] ma, mb, prod;
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic        flag_q;
	// divider
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0]  dcnt_q;
	logic        dbusy_q;
	logic [32:0] dtrial;
	logic [31:0] drem_sh;

	assign t1 = {16'd0, temp_cal[15:0]};
	assign t2 = sx16(temp_cal[31:16]);
	assign t3 = sx16(temp_cal[47:32]);
	assign p1 = {16'd0, press_cal_low[15:0]};
	assign p2 = sx16(press_cal_low[31:16]);
	assign p3 = sx16(press_cal_low[47:32]);
	assign p4 = sx16(press_cal_low[63:48]);
	assign p5 = sx16(press_cal_high[15:0]);
	assign p6 = sx16(press_cal_high[31:16]);
	assign p7 = sx16(press_cal_high[47:32]);
	assign p8 = sx16(press_cal_high[63:48]);
	assign p9 = sx16(press_cal_last);

	// operand select for the single 32x32 multiplier (low half kept)
	always_comb begin
		ma = a_q;
		mb = a_q;
		unique case (cmd.op)
			OP_T_V1:  begin ma = a_q; mb = t2; end
			OP_T_BB:  begin ma = b_q; mb = b_q; end
			OP_T_V2:  begin ma = asr32(c_q, 12); mb = t3; end
			OP_T_RES: begin ma = fine_q; mb = 32'd5; end
			OP_P_SQ:  begin ma = asr32(a_q, 2); mb = asr32(a_q, 2); end
			OP_P_X6:  begin ma = asr32(b_q, 11); mb = p6; end
			OP_P_X5:  begin ma = a_q; mb = p5; end
			OP_P_Y3:  begin ma = p3; mb = asr32(b_q, 13); end
			OP_P_Y2:  begin ma = p2; mb = a_q; end
			OP_P_DEN: begin ma = OneQ15 + a_q; mb = p1; end
			OP_P_NUM: begin ma = (AdcFull - {12'd0, adc_q}) - asr32(c_q, 12);
				mb = PressScale; end
			OP_P_W:   begin ma = {3'd0, b_q[31:3]}; mb = {3'd0, b_q[31:3]}; end
			OP_P_Z9:  begin ma = p9; mb = {13'd0, a_q[31:13]}; end
			OP_P_Z8:  begin ma = {2'd0, b_q[31:2]}; mb = p8; end
			default:  begin ma = a_q; mb = a_q; end
		endcase
	end
	assign prod = ma * mb;

	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};
	assign drem_sh = {dr_q[30:0], dq_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.step && cmd.op == OP_T_FIN)
				fine_q <= a_q + c_q;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= 6'd32;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1)
					dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			adc_q <= in_raw;
			flag_q <= 1'b0;
		end
		if (cmd.div_start) begin
			// numerator chosen per the two overflow-avoiding forms
			dq_q <= (c_q < SignBit) ? {c_q[30:0], 1'b0} : c_q;
			dr_q <= '0;
			dd_q <= a_q;
		end else if (dbusy_q) begin
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= drem_sh;
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (cmd.step) begin
			unique case (cmd.op)
				OP_T_A:   a_q <= {15'd0, adc_q[19:3]} - {t1[30:0], 1'b0};
				OP_T_V1:  a_q <= asr32(prod, 11);
				OP_T_B:   b_q <= {16'd0, adc_q[19:4]} - t1;
				OP_T_BB:  c_q <= prod;
				OP_T_V2:  c_q <= asr32(prod, 14);
				OP_T_FIN: ;
				OP_T_RES: d_q <= asr32(prod + RoundHalf, 8);
				OP_P_V1:  a_q <= asr32(fine_q, 1) - PressOffset;
				OP_P_SQ:  b_q <= prod;
				OP_P_X6:  c_q <= prod;
				OP_P_X5:  c_q <= c_q + {prod[30:0], 1'b0};
				OP_P_V2:  c_q <= asr32(c_q, 2) + {p4[15:0], 16'd0};
				OP_P_Y3:  d_q <= asr32(prod, 3);
				OP_P_Y2:  a_q <= asr32(d_q + asr32(prod, 1), 18);
				OP_P_Y1:  ;
				OP_P_DEN: a_q <= asr32(prod, 15);
				OP_P_NUM: begin c_q <= prod; flag_q <= (a_q == '0); end
				OP_P_DIV: b_q <= (c_q < SignBit) ? dq_q : {dq_q[30:0], 1'b0};
				OP_P_W:   a_q <= prod;
				OP_P_Z9:  d_q <= asr32(prod, 12);
				OP_P_Z8:  c_q <= asr32(prod, 13);
				OP_P_RES: d_q <= flag_q ? '0 : b_q + asr32(d_q + c_q + p7, 4);
				default:  ;
			endcase
		end
	end

	assign stat.kind = kind_q;
	assign stat.div_busy = dbusy_q;
	assign stat.den_zero = flag_q;
	assign res_value = d_q;
	assign res_flag = flag_q & kind_q;

endmodule

>>> rtl/bsc_ctrl.sv
// Sequencer for the compensation steps and the result handshake.
`timescale 1ns / 1ps
module bsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	bsc_sample_if.sink        smp,
	bsc_result_if.source      res,
	output bsc_pkg::dp_cmd_t  cmd,
	input  bsc_pkg::dp_stat_t stat,
	input  logic [31:0]       res_value,
	input  logic              res_flag
);
	import bsc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_DIVS = 5'b00100,
		ST_DIVW = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_q;
	logic   out_kind_q, out_flag_q;
	logic [31:0] out_value_q;
	logic   out_free;

	assign out_free = !out_valid_q || res.ready;
	assign smp.ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		cmd = '{load: 1'b0, step: 1'b0, op: op_q, div_start: 1'b0, take: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (smp.valid) begin
					cmd.load = 1'b1;
					state_d = ST_RUN;
					op_d = smp.kind ? OP_P_V1 : OP_T_A;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				unique case (op_q)
					OP_T_RES, OP_P_RES: state_d = ST_DONE;
					OP_P_NUM: begin state_d = ST_DIVS; op_d = OP_P_DIV; end
					default: op_d = op_t'(op_q + 5'd1);
				endcase
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIVW;
			end
			ST_DIVW: begin
				if (!stat.div_busy) begin
					cmd.step = 1'b1;
					state_d = ST_RUN;
					// zero divisor skips to the final op, which forces zero
					op_d = stat.den_zero ? OP_P_RES : OP_P_W;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.take = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			if (cmd.take)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			out_value_q <= res_value;
			out_kind_q <= stat.kind;
			out_flag_q <= res_flag;
		end
	end

	assign res.valid = out_valid_q;
	assign res.result_value = out_value_q;
	assign res.result_kind = out_kind_q;
	assign res.divisor_zero = out_flag_q;

`ifndef NO_ASSERTIONS
	a_take_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == ST_DONE) else $error("take outside done");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready) |-> !cmd.take) else $error("result overwritten");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy) else $error("divider restarted");
	a_temp_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !stat.kind) |-> !res_flag) else $error("flag on temperature");
`endif

endmodule

>>> rtl/bsc_regs.sv
// APB calibration register file.
`timescale 1ns / 1ps
module bsc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bsc_pkg::CfgAddrWidth-1:0]  paddr,
	input  logic [bsc_pkg::CfgDataWidth-1:0]  pwdata,
	output logic [bsc_pkg::CfgDataWidth-1:0]  prdata,
	output logic                              pready,
	output logic [47:0]                       temp_cal,
	output logic [63:0]                       press_cal_low,
	output logic [63:0]                       press_cal_high,
	output logic [15:0]                       press_cal_last
);
	import bsc_pkg::*;

	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal <= '0;
			press_cal_low <= '0;
			press_cal_high <= '0;
			press_cal_last <= '0;
		end else if (wr) begin
			unique case (paddr)
				AddrTempCal:   temp_cal <= pwdata[47:0];
				AddrPressLow:  press_cal_low <= pwdata;
				AddrPressHigh: press_cal_high <= pwdata;
				AddrPressLast: press_cal_last <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			AddrTempCal:   prdata = {16'd0, temp_cal};
			AddrPressLow:  prdata = press_cal_low;
			AddrPressHigh: prdata = press_cal_high;
			AddrPressLast: prdata = {48'd0, press_cal_last};
			default:       prdata = '0;
		endcase
	end

endmodule

>>> rtl/baro_sensor_compensation.sv
// Top level of the barometric sensor compensation block.
// Temperature transaction: steps OP_T_A to OP_T_RES, result then registered.
// Pressure transaction: steps up to a serial divide, cut short on a zero divisor.
// One sample in flight at a time; the output register frees the sequencer early.
// arst_n clears the sequencer, output valid, calibration and fine temperature.
// Calibration may be written over APB only while the block is idle.
`timescale 1ns / 1ps
module baro_sensor_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	bsc_sample_if.sink                       smp,
	bsc_result_if.source                     res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bsc_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [bsc_pkg::CfgDataWidth-1:0] pwdata,
	output logic [bsc_pkg::CfgDataWidth-1:0] prdata,
	output logic                             pready
);
	import bsc_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [47:0] temp_cal;
	logic [63:0] press_cal_low, press_cal_high;
	logic [15:0] press_cal_last;
	logic [31:0] res_value;
	logic        res_flag;

	// calibration words
	bsc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.temp_cal, .press_cal_low, .press_cal_high, .press_cal_last
	);

	// sequencer owns both handshakes
	bsc_ctrl u_ctrl (
		.clk, .arst_n, .smp, .res, .cmd, .stat, .res_value, .res_flag
	);

	// arithmetic: one multiplier, one serial divider
	bsc_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_kind(smp.kind), .in_raw(smp.raw_sample),
		.temp_cal, .press_cal_low, .press_cal_high, .press_cal_last,
		.res_value, .res_flag
	);

endmodule

>>> dv/bsc_checker.sv
// Checker: watches both channels and the APB port, predicts compensated values, compares.
`timescale 1ns / 1ps
module bsc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             smp_valid,
	input  logic                             smp_ready,
	input  logic                             smp_kind,
	input  logic [bsc_pkg::SampleWidth-1:0]  smp_raw,
	input  logic                             res_valid,
	input  logic                             res_ready,
	input  logic                             res_kind,
	input  logic [bsc_pkg::ValueWidth-1:0]   res_value,
	input  logic                             res_dz,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [bsc_pkg::CfgAddrWidth-1:0] paddr,
	input  logic [bsc_pkg::CfgDataWidth-1:0] pwdata,
	output int                               fail_count,
	output int                               pending,
	output int                               result_count,
	output int                               dz_count
);
	import bsc_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic        dz;
	} comp_t;

	comp_t       expected_q[$];
	logic [47:0] cal_t;
	logic [63:0] cal_pl;
	logic [63:0] cal_ph;
	logic [15:0] cal_p9;
	logic [31:0] t_fine;

	function automatic logic [31:0] sar(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] ext(input logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

	// one compensation step; updates t_fine on temperature samples
	function automatic comp_t compensate(input logic k, input logic [19:0] adc);
		comp_t r;
		logic [31:0] t1, a, v1, b, v2, q, sq, p, w;
		r.kind = k;
		r.dz = 1'b0;
		if (!k) begin
			t1 = {16'd0, cal_t[15:0]};
			a = {15'd0, adc[19:3]} - (t1 << 1);
			v1 = sar(a * ext(cal_t[31:16]), 11);
			b = {16'd0, adc[19:4]} - t1;
			v2 = sar(sar(b * b, 12) * ext(cal_t[47:32]), 14);
			t_fine = v1 + v2;
			r.value = sar(t_fine * 32'd5 + 32'd128, 8);
		end else begin
			v1 = sar(t_fine, 1) - 32'd64000;
			q = sar(v1, 2);
			sq = q * q;
			v2 = sar(sq, 11) * ext(cal_ph[31:16]);
			v2 = v2 + ((v1 * ext(cal_ph[15:0])) << 1);
			v2 = sar(v2, 2) + (ext(cal_pl[63:48]) << 16);
			v1 = sar(sar(ext(cal_pl[47:32]) * sar(sq, 13), 3)
				+ sar(ext(cal_pl[31:16]) * v1, 1), 18);
			v1 = sar((32'd32768 + v1) * {16'd0, cal_pl[15:0]}, 15);
			if (v1 == '0) begin
				r.value = '0;
				r.dz = 1'b1;
			end else begin
				p = ((32'd1048576 - {12'd0, adc}) - sar(v2, 12)) * 32'd3125;
				if (p < 32'h8000_0000) p = (p << 1) / v1;
				else p = (p / v1) << 1;
				w = ((p >> 3) * (p >> 3)) >> 13;
				v1 = sar(ext(cal_p9) * w, 12);
				v2 = sar((p >> 2) * ext(cal_ph[63:48]), 13);
				r.value = p + sar(v1 + v2 + ext(cal_ph[47:32]), 4);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		comp_t e;
		if (!arst_n) begin
			cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0; t_fine = '0;
			expected_q.delete();
			fail_count = 0;
			result_count = 0;
			dz_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					AddrTempCal:   cal_t = pwdata[47:0];
					AddrPressLow:  cal_pl = pwdata;
					AddrPressHigh: cal_ph = pwdata;
					AddrPressLast: cal_p9 = pwdata[15:0];
					default: ;
				endcase
			end
			if (smp_valid && smp_ready)
				expected_q.push_back(compensate(smp_kind, smp_raw));
			if (res_valid && res_ready) begin
				result_count++;
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: kind %0d value %0h", res_kind, res_value);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (e.dz) dz_count++;
					if (res_kind !== e.kind) begin
						$error("result_kind: expected %0d actual %0d", e.kind, res_kind);
						fail_count++;
					end
					if (res_value !== e.value) begin
						$error("result_value: expected %0h actual %0h", e.value, res_value);
						fail_count++;
					end
					if (res_dz !== e.dz) begin
						$error("divisor_zero: expected %0d actual %0d", e.dz, res_dz);
						fail_count++;
					end
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

>>> dv/tb_top.sv
// Testbench top: clock, reset, APB calibration writes, sample stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import bsc_pkg::*;

	localparam int WatchLimit = 20000;   // idle cycles
	localparam int DrainCycles = 80;     // covers the longest (pressure) latency

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [CfgAddrWidth-1:0] paddr = '0;
	logic [CfgDataWidth-1:0] pwdata = '0;
	logic [CfgDataWidth-1:0] prdata;
	logic pready;

	int fail_count, pending, result_count, dz_count;
	int send_idle_pct = 0;   // percent of cycles the sender holds back
	int recv_stall_pct = 0;  // percent of cycles the receiver stalls
	bit hold_off = 1'b0;     // long receiver hold-off for back-pressure
	bit stim_done = 1'b0;
	int quiet_cycles = 0;
	int sent = 0;

	bsc_sample_if smp ();
	bsc_result_if res ();

	always #2 clk = ~clk;

	baro_sensor_compensation uut (
		.clk, .arst_n, .smp(smp.sink), .res(res.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	bsc_checker chk (
		.clk, .arst_n,
		.smp_valid(smp.valid), .smp_ready(smp.ready), .smp_kind(smp.kind),
		.smp_raw(smp.raw_sample),
		.res_valid(res.valid), .res_ready(res.ready), .res_kind(res.result_kind),
		.res_value(res.result_value), .res_dz(res.divisor_zero),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending, .result_count, .dz_count
	);

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("watchdog expired, %0d results still expected", pending);
			$display("baro_sensor_compensation regression: fail");
			$finish;
		end
	end

	task automatic apb_write(input logic [CfgAddrWidth-1:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic load_cal(input logic [47:0] t, input logic [63:0] pl,
			input logic [63:0] ph, input logic [15:0] p9);
		apb_write(AddrTempCal, {16'd0, t});
		apb_write(AddrPressLow, pl);
		apb_write(AddrPressHigh, ph);
		apb_write(AddrPressLast, {48'd0, p9});
	endtask

	// one sample transaction; valid stays high back to back when no idle is drawn,
	// the idle loop or drain() lowers it
	task automatic send_sample(input logic k, input logic [19:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.kind <= k;
		smp.raw_sample <= raw;
		do @(posedge clk); while (!smp.ready);
		sent++;
	endtask

	// stop offering, wait for all expectations, then for the block's own latency
	task automatic drain();
		smp.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// realistic calibration set near typical factory values
	task automatic typical_cal();
		load_cal({16'hFF18 /*-232*/, 16'd26435, 16'd27504},
			{16'd2855, 16'hD050 /*-12208*/, 16'hF8D8 /*-1832*/, 16'd36477},
			{16'hFF9C /*P8*/, 16'd15500, 16'hFFF9 /*P6*/, 16'd140},
			16'd6000);
	endtask

	task automatic random_cal();
		load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
			16'($urandom));
	endtask

	// sensor readings: a temperature then three pressures, with about one in ten samples fully random
	task automatic random_burst(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_sample(1'($urandom_range(1)), 20'($urandom));
			else if (i % 4 == 0)
				send_sample(1'b0, 20'($urandom_range(560000, 470000)));
			else
				send_sample(1'b1, 20'($urandom_range(440000, 250000)));
		end
	endtask

	initial begin
		int phase;
		smp.valid <= 1'b0;
		smp.kind <= 1'b0;
		smp.raw_sample <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset calibration gives a zero divisor on pressure,
		// and a pressure before any temperature uses zero fine temperature.
		send_sample(1'b1, 20'd0);
		send_sample(1'b0, 20'd0);
		send_sample(1'b0, 20'hFFFFF);
		send_sample(1'b1, 20'hFFFFF);
		drain();

		typical_cal();
		send_sample(1'b1, 20'd415148);       // pressure using the fine temperature left from the previous block
		send_sample(1'b0, 20'd519888);
		send_sample(1'b1, 20'd415148);
		send_sample(1'b1, 20'd0);
		send_sample(1'b1, 20'hFFFFF);
		send_sample(1'b0, 20'hFFFFF);
		send_sample(1'b1, 20'h55555);
		send_sample(1'b0, 20'hAAAAA);
		send_sample(1'b1, 20'hAAAAA);
		drain();

		// extremes of the calibration words: wrapping intermediates
		load_cal({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
			{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
		send_sample(1'b0, 20'hFFFFF);
		send_sample(1'b1, 20'd0);
		send_sample(1'b0, 20'd0);
		send_sample(1'b1, 20'hFFFFF);
		drain();
		load_cal({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
		send_sample(1'b0, 20'h12345);
		send_sample(1'b1, 20'h6789A);
		send_sample(1'b1, 20'hFFFFF);
		drain();

		// random phases over the idling profiles
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			if (phase == 3 || phase == 7) random_cal();
			else if (phase == 5) load_cal('0, '0, '0, '0);
			else typical_cal();
			if (phase == 4) begin
				// long receiver hold-off while samples keep coming
				fork
					begin
						hold_off <= 1'b1;
						repeat (400) @(posedge clk);
						hold_off <= 1'b0;
					end
					random_burst(60);
				join
			end else begin
				random_burst(60);
			end
			drain();
		end
		stim_done = 1'b1;

		$display("covered %0d samples, %0d results (%0d with zero divisor)",
			sent, result_count, dz_count);
		$display("over 4 idling profiles, typical, extreme, zero and random calibration");
		if (fail_count == 0)
			$display("baro_sensor_compensation regression: pass");
		else
			$display("baro_sensor_compensation regression: fail");
		$finish;
	end
endmodule
